// File: hw/rtl/uep0_pkg.sv
package uep0_pkg;

  // Command queue depth between classifier and emitter
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] UsbRelease   = 16'h0110;
  localparam logic [6:0]  Ep0MaxPacket = 7'd64;
  localparam logic [4:0]  DevDescLen   = 5'd18;
  localparam logic [4:0]  QualDescLen  = 5'd10;
  localparam logic [4:0]  StatusLen    = 5'd2;
  localparam logic [4:0]  SingleLen    = 5'd1;

  localparam logic [7:0] ReqGetStatus     = 8'h00;
  localparam logic [7:0] ReqGetDescriptor = 8'h06;
  localparam logic [7:0] ReqSetConfig     = 8'h09;

  localparam logic [7:0] DescDevice    = 8'h01;
  localparam logic [7:0] DescConfig    = 8'h02;
  localparam logic [7:0] DescQualifier = 8'h06;

  localparam int unsigned DirBit = 7;
  localparam logic [4:0] RecipDevice    = 5'd0;
  localparam logic [4:0] RecipInterface = 5'd1;

  typedef enum logic [2:0] {
    CFG_VENDOR_ID,
    CFG_PRODUCT_ID,
    CFG_DEVICE_RELEASE,
    CFG_DEVICE_CLASS,
    CFG_DEVICE_SUBCLASS,
    CFG_DEVICE_PROTOCOL,
    CFG_CONFIG_COUNT
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_ZLP,
    ST_STALL,
    ST_FWD
  } reply_status_e;

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_STATUS,
    CMD_DEVICE,
    CMD_QUALIFIER
  } cmd_kind_e;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] device_release;
    logic [7:0]  device_class;
    logic [7:0]  device_subclass;
    logic [7:0]  device_protocol_code;
    logic [7:0]  configuration_count;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  descriptor_index;
    logic [7:0]  descriptor_kind;
    logic [15:0] transfer_length;
  } req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic [1:0] reply_status;
    logic       reply_last;
    logic       configured;
  } res_t;

  typedef struct packed {
    cmd_kind_e     kind;
    reply_status_e status;
    logic          configured;
    logic [6:0]    max_packet;
  } cmd_t;

  function automatic logic [4:0] cmd_length(cmd_kind_e kind);
    logic [4:0] len;
    case (kind)
      CMD_STATUS:    len = StatusLen;
      CMD_DEVICE:    len = DevDescLen;
      CMD_QUALIFIER: len = QualDescLen;
      default:       len = SingleLen;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] desc_byte(cmd_kind_e kind, logic [4:0] pos, cfg_t cfg,
                                           logic [6:0] max_packet);
    logic [7:0] b;
    b = '0;
    case (kind)
      CMD_STATUS: begin
        b = (pos == 5'd0) ? 8'h01 : 8'h00;
      end
      CMD_DEVICE: begin
        case (pos)
          5'd0:    b = {3'b000, DevDescLen};
          5'd1:    b = DescDevice;
          5'd2:    b = UsbRelease[7:0];
          5'd3:    b = UsbRelease[15:8];
          5'd4:    b = cfg.device_class;
          5'd5:    b = cfg.device_subclass;
          5'd6:    b = cfg.device_protocol_code;
          5'd7:    b = {1'b0, max_packet};
          5'd8:    b = cfg.vendor_id[7:0];
          5'd9:    b = cfg.vendor_id[15:8];
          5'd10:   b = cfg.product_id[7:0];
          5'd11:   b = cfg.product_id[15:8];
          5'd12:   b = cfg.device_release[7:0];
          5'd13:   b = cfg.device_release[15:8];
          5'd17:   b = cfg.configuration_count;
          default: b = 8'h00;
        endcase
      end
      CMD_QUALIFIER: begin
        case (pos)
          5'd0:    b = {3'b000, QualDescLen};
          5'd1:    b = DescQualifier;
          5'd2:    b = UsbRelease[7:0];
          5'd3:    b = UsbRelease[15:8];
          5'd4:    b = cfg.device_class;
          5'd5:    b = cfg.device_subclass;
          5'd6:    b = cfg.device_protocol_code;
          5'd7:    b = {1'b0, Ep0MaxPacket};
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/uep0_front.sv
module uep0_front import uep0_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  req_t       req_i,
  input  logic [7:0] cfg_count_i,
  output cmd_t       cmd_o,
  output logic       configured_o
);

  logic       configured_q, configured_d;
  logic [4:0] recipient;
  logic [6:0] max_packet;

  assign recipient  = req_i.request_type[4:0];
  assign max_packet = (req_i.transfer_length < 16'(Ep0MaxPacket)) ?
                      req_i.transfer_length[6:0] : Ep0MaxPacket;

  // Classify the setup beat and compute the flag it leaves behind
  always_comb begin
    configured_d     = configured_q;
    cmd_o.kind       = CMD_SINGLE;
    cmd_o.status     = ST_STALL;
    cmd_o.max_packet = max_packet;
    if (req_i.mode) begin
      configured_d = 1'b0;
      cmd_o.status = ST_ZLP;
    end else if (recipient == RecipInterface) begin
      cmd_o.status = ST_FWD;
    end else if (recipient != RecipDevice) begin
      cmd_o.status = ST_STALL;
    end else if (!req_i.request_type[DirBit]) begin
      if (req_i.request_code == ReqSetConfig) begin
        configured_d = 1'b1;
        cmd_o.status = ST_ZLP;
      end
    end else if (req_i.request_code == ReqGetStatus) begin
      cmd_o.kind = CMD_STATUS;
    end else if (req_i.request_code != ReqGetDescriptor) begin
      cmd_o.status = ST_ZLP;
    end else if (req_i.descriptor_kind == DescDevice) begin
      cmd_o.kind = CMD_DEVICE;
    end else if (req_i.descriptor_kind == DescQualifier) begin
      cmd_o.kind = CMD_QUALIFIER;
    end else if (req_i.descriptor_kind == DescConfig) begin
      cmd_o.status = (req_i.descriptor_index < cfg_count_i) ? ST_FWD : ST_STALL;
    end
    cmd_o.configured = configured_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      configured_q <= 1'b0;
    end else if (accept_i) begin
      configured_q <= configured_d;
    end
  end

  assign configured_o = configured_q;

endmodule

// File: hw/rtl/uep0_cmd_queue.sv
module uep0_cmd_queue import uep0_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output logic rd_valid_o,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/uep0_back.sv
module uep0_back import uep0_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  cfg_t cfg_i,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  logic [4:0] pos_q, pos_d;
  logic       load, last;

  // Load a new beat when the output register is free or drains this cycle
  assign load = cmd_valid_i && (!out_valid_q || pop_i);
  assign last = (pos_q == cmd_length(cmd_i.kind) - 5'd1);

  always_comb begin
    res_d.reply_last = last;
    res_d.configured = cmd_i.configured;
    if (cmd_i.kind == CMD_SINGLE) begin
      res_d.reply_byte   = 8'h00;
      res_d.reply_status = cmd_i.status;
    end else begin
      res_d.reply_byte   = desc_byte(cmd_i.kind, pos_q, cfg_i, cmd_i.max_packet);
      res_d.reply_status = ST_DATA;
    end
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !pop_i;
    if (load) begin
      pos_d       = last ? 5'd0 : pos_q + 5'd1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 5'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign cmd_pop_o = load && last;
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;

endmodule

// File: hw/rtl/usb_ep0_standard_request_responder.sv
// Endpoint-0 standard request responder. Push one setup packet (or a disconnect
// event, mode = 1) per beat; each one yields a stream of result beats, the final
// one marked reply_last, all carrying the configured flag as it stands after that
// input. A classifier takes a request in every cycle into a QDepth-entry
// command queue, so full only rises when the emitter falls behind. The emitter
// produces one result beat per cycle while pop keeps up: a request yields one
// beat for a single status, 2 for get status, 10 for qualifier, 18 for device
// descriptor, via the emitter's byte counter. Descriptor fields come from the
// config registers, written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// no request is in flight: the user must keep to this, the block does not enforce it.
module usb_ep0_standard_request_responder import uep0_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  req_t        req_i,
  output logic        empty,
  input  logic        pop,
  output res_t        res_o
);

  cfg_t cfg_q;
  logic accept;
  cmd_t front_cmd, head_cmd;
  logic head_valid, head_pop;
  logic configured;

  // Hold the configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{vendor_id:            16'h0000,
                 product_id:           16'h0000,
                 device_release:       16'h0000,
                 device_class:         8'h00,
                 device_subclass:      8'h00,
                 device_protocol_code: 8'h00,
                 configuration_count:  8'd1};
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_idx_i))
        CFG_VENDOR_ID:       cfg_q.vendor_id            <= cfg_wdata_i;
        CFG_PRODUCT_ID:      cfg_q.product_id           <= cfg_wdata_i;
        CFG_DEVICE_RELEASE:  cfg_q.device_release       <= cfg_wdata_i;
        CFG_DEVICE_CLASS:    cfg_q.device_class         <= cfg_wdata_i[7:0];
        CFG_DEVICE_SUBCLASS: cfg_q.device_subclass      <= cfg_wdata_i[7:0];
        CFG_DEVICE_PROTOCOL: cfg_q.device_protocol_code <= cfg_wdata_i[7:0];
        CFG_CONFIG_COUNT:    cfg_q.configuration_count  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Accept a request beat whenever the command queue has room
  assign accept = push && !full;

  uep0_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req_i),
    .cfg_count_i  (cfg_q.configuration_count),
    .cmd_o        (front_cmd),
    .configured_o (configured)
  );

  uep0_cmd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept),
    .wr_data_i  (front_cmd),
    .full_o     (full),
    .rd_en_i    (head_pop),
    .rd_valid_o (head_valid),
    .rd_data_o  (head_cmd)
  );

  // Advance the head command one result beat per cycle while pop keeps up
  uep0_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .cfg_i       (cfg_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res_o)
  );

  // A status-only beat always closes its stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.reply_status != 2'(ST_DATA)) |-> res_o.reply_last)
    else $error("non-data result beat without reply_last");

  // A disconnect clears the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.mode) |=> !configured)
    else $error("configured flag survived a disconnect");

  // Set configuration on the device sets the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_i.mode && req_i.request_type[4:0] == RecipDevice &&
     !req_i.request_type[DirBit] && req_i.request_code == ReqSetConfig) |=> configured)
    else $error("configured flag not set by set configuration");

  // The emitter never takes a command from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("command queue popped while empty");

endmodule
